### rtl/sch_pkg.sv
// ----------------------------------------------------------------------------
// sch_pkg
// Types and constants shared by the sorted character histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package sch_pkg;

    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 6;
    localparam int TABLE_DEPTH  = 1 << CHAR_W;
    localparam int WORD_MAX     = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int SEEN_W       = $clog2(WORD_MAX + 1);
    localparam int DIST_W       = $clog2(WORD_MAX + 1);
    localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

    localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_UP_LO = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_UP_HI = 8'h5A;
    localparam logic [CHAR_W-1:0]  CASE_SHIFT = 8'h61 - 8'h41;
    localparam logic [COUNT_W-1:0] COUNT_CAP  = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_word;
    } sch_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic [COUNT_W-1:0] occurrences;
        logic               last_entry;
        logic               overflowed;
    } sch_out_t;

endpackage

`default_nettype wire

### rtl/sorted_char_histogram_core.sv
// ----------------------------------------------------------------------------
// sorted_char_histogram_core
// Counts the case-folded characters of a word in a 256-entry table and reads
// the nonzero entries back in ascending byte order when the word ends.
// ----------------------------------------------------------------------------
// A character transfer reads its table entry when taken and writes the
// incremented count back in ST_RMW, with busy high; a character dropped beyond
// the word limit only sets the overflow flag. An end transfer, or a zero
// character, sweeps all 256 table entries at one entry per cycle, emitting one
// result strobe for each distinct character while clearing the table. After
// reset the table is cleared in one pass with busy high. Results appear for
// exactly one cycle on result_valid and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_char_histogram_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire sch_pkg::sch_in_t item,
    output logic                  result_valid,
    output sch_pkg::sch_out_t     result
);

    import sch_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CHAR_W-1:0]   addr_reg, addr_next;
    logic                issue_reg, issue_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CHAR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [EMIT_W-1:0]   emit_reg, emit_next;
    logic                ovf_reg, ovf_next;
    logic                result_valid_reg, result_valid_next;
    sch_out_t            result_reg, result_next;

    logic                ram_we;
    logic [CHAR_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic [CHAR_W-1:0]   ram_raddr;
    logic [COUNT_W-1:0]  ram_rdata;

    logic [CHAR_W-1:0]   folded;
    logic [EMIT_W-1:0]   emit_total;
    logic                ovf_out;

    sch_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign folded = (item.char_in >= CHAR_UP_LO && item.char_in <= CHAR_UP_HI)
                    ? item.char_in + CASE_SHIFT : item.char_in;

    assign emit_total = (dist_reg > DIST_W'(RESULT_LIMIT))
                        ? EMIT_W'(RESULT_LIMIT) : EMIT_W'(dist_reg);
    assign ovf_out    = ovf_reg || (dist_reg > DIST_W'(RESULT_LIMIT));

    always_comb
    begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        issue_next        = issue_reg;
        pend_valid_next   = 1'b0;
        pend_addr_next    = pend_addr_reg;
        seen_next         = seen_reg;
        dist_next         = dist_reg;
        emit_next         = emit_reg;
        ovf_next          = ovf_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = '0;
        ram_raddr         = addr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = folded;
                if (start)
                begin
                    if (item.end_of_word || item.char_in == CHAR_NUL)
                    begin
                        state_next = ST_SCAN;
                        addr_next  = '0;
                        issue_next = 1'b1;
                    end
                    else if (seen_reg >= SEEN_W'(WORD_MAX))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        addr_next  = folded;
                        seen_next  = seen_reg + 1'b1;
                        state_next = ST_RMW;
                    end
                end
            end
            ST_RMW:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = (ram_rdata < COUNT_CAP) ? ram_rdata + 1'b1 : ram_rdata;
                if (ram_rdata == '0)
                begin
                    dist_next = dist_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                ram_raddr = addr_reg;
                if (issue_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = addr_reg;
                    addr_next       = addr_reg + 1'b1;
                    if (addr_reg == '1)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    if (ram_rdata != '0 && emit_reg < EMIT_W'(RESULT_LIMIT))
                    begin
                        result_valid_next       = 1'b1;
                        result_next.char_out    = pend_addr_reg;
                        result_next.occurrences = ram_rdata;
                        result_next.last_entry  = (emit_reg + 1'b1) == emit_total;
                        result_next.overflowed  = ovf_out;
                        emit_next               = emit_reg + 1'b1;
                    end
                    if (pend_addr_reg == '1)
                    begin
                        state_next = ST_IDLE;
                        seen_next  = '0;
                        dist_next  = '0;
                        emit_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            addr_reg         <= '0;
            issue_reg        <= 1'b0;
            pend_valid_reg   <= 1'b0;
            seen_reg         <= '0;
            dist_reg         <= '0;
            emit_reg         <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            issue_reg        <= issue_next;
            pend_valid_reg   <= pend_valid_next;
            seen_reg         <= seen_next;
            dist_reg         <= dist_next;
            emit_reg         <= emit_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        result_reg    <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### rtl/sch_ram.sv
// ----------------------------------------------------------------------------
// sch_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sch_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_char_histogram_core. Words of random
// characters are sent as command transfers, and a local model of the
// case-folding histogram builds the sorted readout each word should produce.
// Every result strobe is checked against it, field by field.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sch_pkg::*;

    localparam int TARGET_ITEMS = 470;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 300;

    logic     clk    = 1'b0;
    logic     rst_n  = 1'b0;
    logic     start  = 1'b0;
    sch_in_t  item   = '0;
    logic     busy;
    logic     result_valid;
    sch_out_t result;

    sch_in_t  word_stream [$];
    sch_out_t readout_q [$];

    logic [COUNT_W-1:0] tally [TABLE_DEPTH];
    int unsigned        seen_cnt;
    bit                 dropped;

    int  fail_count = 0;
    int  item_count = 0;
    int  cycle_cnt  = 0;
    int  gap_cnt    = 0;
    bit  no_idle    = 1'b0;

    sorted_char_histogram_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_tally();
        for (int v = 0; v < TABLE_DEPTH; v++)
        begin
            tally[v] = '0;
        end
        seen_cnt = 0;
        dropped  = 1'b0;
    endfunction

    function automatic void tally_item(sch_in_t it);
        logic [CHAR_W-1:0] c;
        int                n;
        bit                ovf;
        sch_out_t          r;
        if (it.end_of_word || it.char_in == CHAR_NUL)
        begin
            ovf = dropped;
            n   = 0;
            for (int v = 0; v < TABLE_DEPTH; v++)
            begin
                if (tally[v] != '0)
                begin
                    if (n < RESULT_LIMIT)
                        n++;
                    else
                        ovf = 1'b1;
                end
            end
            n = 0;
            for (int v = 0; v < TABLE_DEPTH && n < RESULT_LIMIT; v++)
            begin
                if (tally[v] != '0)
                begin
                    r.char_out    = CHAR_W'(v);
                    r.occurrences = tally[v];
                    r.last_entry  = 1'b0;
                    r.overflowed  = ovf;
                    readout_q.push_back(r);
                    n++;
                end
            end
            if (n > 0)
            begin
                r = readout_q.pop_back();
                r.last_entry = 1'b1;
                readout_q.push_back(r);
            end
            clear_tally();
        end
        else
        begin
            c = it.char_in;
            if (c >= CHAR_UP_LO && c <= CHAR_UP_HI)
                c = c + CASE_SHIFT;
            if (seen_cnt >= WORD_MAX)
            begin
                dropped = 1'b1;
            end
            else
            begin
                seen_cnt++;
                if (tally[c] != COUNT_CAP)
                    tally[c] = tally[c] + 1'b1;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        int g;
        if (rst_n)
        begin
            g = gap_cnt;
            if (start && !busy)
            begin
                tally_item(item);
                g = pick_gap();
            end
            if (!(start && busy))
            begin
                if (g > 0)
                begin
                    start   <= 1'b0;
                    gap_cnt <= g - 1;
                end
                else if (word_stream.size() > 0)
                begin
                    item    <= word_stream.pop_front();
                    start   <= 1'b1;
                    gap_cnt <= 0;
                end
                else
                begin
                    start   <= 1'b0;
                    gap_cnt <= 0;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        sch_out_t want;
        if (rst_n && result_valid)
        begin
            if (readout_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual char %0h count %0d",
                         $time, result.char_out, result.occurrences);
                fail_count++;
            end
            else
            begin
                want = readout_q.pop_front();
                check_field("char_out", want.char_out, result.char_out);
                check_field("occurrences", want.occurrences, result.occurrences);
                check_field("last_entry", want.last_entry, result.last_entry);
                check_field("overflowed", want.overflowed, result.overflowed);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_item(logic [CHAR_W-1:0] c, logic eow);
        sch_in_t it;
        it.char_in     = c;
        it.end_of_word = eow;
        word_stream.push_back(it);
        item_count++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(int alphabet);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CHAR_W'(8'h61 + $urandom_range(0, alphabet - 1));
        else if (r < 65)
            return CHAR_W'(8'h41 + $urandom_range(0, alphabet - 1));
        else
            return CHAR_W'($urandom_range(1, 255));
    endfunction

    task automatic push_end();
        if ($urandom_range(0, 99) < 70)
            push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
        else
            push_item(CHAR_NUL, 1'b0);
    endtask

    task automatic push_word(int len, int alphabet);
        for (int i = 0; i < len; i++)
        begin
            push_item(pick_char(alphabet), 1'b0);
        end
        push_end();
    endtask

    task automatic wait_drained();
        while (word_stream.size() > 0 || start || readout_q.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int kind;
        bit paused;
        clear_tally();
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        push_item(8'h41, 1'b0);
        push_item(8'h5A, 1'b0);
        push_item(8'h61, 1'b0);
        push_item(8'h7A, 1'b0);
        push_item(8'h40, 1'b0);
        push_item(8'h5B, 1'b0);
        push_item(8'h60, 1'b0);
        push_item(8'h7B, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h4D, 1'b0);
        push_item(8'h6D, 1'b0);
        push_item(8'hA5, 1'b1);
        push_item(8'h00, 1'b1);
        push_item(8'h71, 1'b0);
        push_item(8'h51, 1'b0);
        push_item(CHAR_NUL, 1'b0);
        push_item(8'hFF, 1'b1);

        wait_drained();

        while (item_count < TARGET_ITEMS)
        begin
            if (!paused && item_count >= TARGET_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                push_word($urandom_range(1, 12), $urandom_range(3, 26));
            end
            else if (kind < 72)
            begin
                push_word($urandom_range(30, 40), $urandom_range(2, 26));
            end
            else if (kind < 82)
            begin
                for (int i = $urandom_range(20, 36); i > 0; i--)
                begin
                    push_item(CHAR_W'($urandom_range(1, 255)), 1'b0);
                end
                push_end();
            end
            else if (kind < 95)
            begin
                for (int i = $urandom_range(5, 20); i > 0; i--)
                begin
                    push_item(CHAR_W'($urandom_range(0, 255)),
                              ($urandom_range(0, 15) == 0));
                end
            end
            else
            begin
                push_end();
            end
            while (word_stream.size() > 8)
            begin
                @(posedge clk);
            end
        end

        push_end();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && readout_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
